// ----- hdl/sida_pkg.sv -----
package sida_pkg;

  localparam int DATA_WIDTH = 32;

  // Number of decimal digits in 2^(width-1), the largest magnitude.
  function automatic int decimal_digits(int width);
    longint unsigned v;
    int n;
    v = 64'd1 << (width - 1);
    n = 0;
    for (int i = 0; i < 20; i++) begin
      if (v != 64'd0) begin
        n++;
        v = v / 64'd10;
      end
    end
    return n;
  endfunction

  localparam int NUM_DIGITS = decimal_digits(DATA_WIDTH);
  localparam int BCD_W      = NUM_DIGITS * 4;
  localparam int BIT_CNT_W  = $clog2(DATA_WIDTH);
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS);

  localparam logic [5:0] CH_MINUS = 6'd45;
  localparam logic [5:0] CH_ZERO  = 6'd48;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SIGN,
    ST_DIGITS
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic emit_sign;
    logic emit_digit;
    logic skip_digit;
  } cmd_t;

  typedef struct packed {
    logic neg;
    logic bits_done;
    logic top_zero;
    logic last_digit;
    logic started;
    logic out_free;
  } sts_t;

endpackage

// ----- hdl/sida_dp.sv -----
module sida_dp import sida_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [DATA_WIDTH-1:0] value,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic                  char_valid,
  input  logic                  char_stall,
  output logic [5:0]            char_code,
  output logic                  last
);

  logic [DATA_WIDTH-1:0] mag;
  logic [BCD_W-1:0]      bcd;
  logic [BCD_W-1:0]      bcd_adj;
  logic                  neg;
  logic [BIT_CNT_W-1:0]  bit_cnt;
  logic [DIG_CNT_W-1:0]  dig_cnt;
  logic                  started;
  logic [3:0]            top_digit;

  assign top_digit = bcd[BCD_W-1 -: 4];

  // Add 3 to every digit of 5 or more before the shift.
  always_comb begin
    logic [3:0] d;
    bcd_adj = bcd;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      d = bcd[4*i +: 4];
      bcd_adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg     <= value[DATA_WIDTH-1];
      mag     <= value[DATA_WIDTH-1] ? (~value + 1'b1) : value;
      bcd     <= '0;
      bit_cnt <= '0;
      dig_cnt <= '0;
      started <= 1'b0;
    end
    if (cmd.shift) begin
      bcd     <= {bcd_adj[BCD_W-2:0], mag[DATA_WIDTH-1]};
      mag     <= {mag[DATA_WIDTH-2:0], 1'b0};
      bit_cnt <= bit_cnt + 1'b1;
    end
    if (cmd.emit_digit || cmd.skip_digit) begin
      bcd     <= {bcd[BCD_W-5:0], 4'b0000};
      dig_cnt <= dig_cnt + 1'b1;
    end
    if (cmd.emit_digit) begin
      started <= 1'b1;
    end
  end

  // Output register: hold while stalled, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      char_valid <= 1'b1;
    end else if (!char_stall) begin
      char_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      char_code <= CH_MINUS;
      last      <= 1'b0;
    end else if (cmd.emit_digit) begin
      char_code <= CH_ZERO + {2'b00, top_digit};
      last      <= sts.last_digit;
    end
  end

  assign sts.neg        = neg;
  assign sts.bits_done  = (bit_cnt == BIT_CNT_W'(DATA_WIDTH - 1));
  assign sts.top_zero   = (top_digit == 4'd0);
  assign sts.last_digit = (dig_cnt == DIG_CNT_W'(NUM_DIGITS - 1));
  assign sts.started    = started;
  assign sts.out_free   = !char_valid || !char_stall;

endmodule

// ----- hdl/sida_ctrl.sv -----
module sida_ctrl import sida_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic value_valid,
  output logic value_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    value_stall = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (value_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        cmd.shift = 1'b1;
        if (sts.bits_done) begin
          state_next = sts.neg ? ST_SIGN : ST_DIGITS;
        end
      end
      ST_SIGN: begin
        if (sts.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        // Drop leading zeros, but always emit the units digit.
        if (sts.top_zero && !sts.started && !sts.last_digit) begin
          cmd.skip_digit = 1'b1;
        end else if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          if (sts.last_digit) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_sign || cmd.emit_digit) |-> sts.out_free)
    else $error("character emitted while output register busy");

  a_no_leading_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_digit && !sts.started && !sts.last_digit) |-> !sts.top_zero)
    else $error("leading zero emitted");

  a_load_starts_fresh: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_CONVERT) && !sts.started)
    else $error("load did not start a conversion");

  a_sign_only_negative: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SIGN) |-> sts.neg)
    else $error("sign state entered for a non-negative value");

endmodule

// ----- hdl/signed_int_to_decimal_ascii_top.sv -----
// Channel   Direction  Handshake                  Payload
// value     in         value_valid / value_stall  value[DATA_WIDTH-1:0], two's complement
// char      out        char_valid / char_stall    char_code[5:0], last
//
// Each request is loaded, then runs DATA_WIDTH shift-and-adjust steps
// (double dabble, one magnitude bit per cycle), then emits a minus sign
// when negative, then runs NUM_DIGITS steps that each either skip a
// leading zero or emit a digit.
// A new request is taken only in the idle state; the last character may
// still sit in the output register while the next request is loaded.
// char_stall holds the character in the output register and pauses emission.
// rst is synchronous and active high; it empties the output register and
// returns the controller to idle.
module signed_int_to_decimal_ascii_top import sida_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  value_valid,
  output logic                  value_stall,
  input  logic [DATA_WIDTH-1:0] value,
  output logic                  char_valid,
  input  logic                  char_stall,
  output logic [5:0]            char_code,
  output logic                  last
);

  // Commands from the sequencer, status back from the datapath.
  cmd_t cmd;
  sts_t sts;

  sida_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  // Magnitude and BCD registers, digit counter, and the output register.
  sida_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .cmd        (cmd),
    .sts        (sts),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_code  (char_code),
    .last       (last)
  );

endmodule
